FILE: hdl/assert_macros.svh
// assertion macros shared by the rasterizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DLR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define DLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/dlr_pkg.sv
// package with constants and types of the dda line rasterizer
package dlr_pkg;

	localparam int FIELD_BITS = 6;
	localparam int COORD_BITS = 6;
	localparam int FRAC_BITS  = 16;

	localparam int NUM_W  = COORD_BITS + FRAC_BITS;
	localparam int QUOT_W = FRAC_BITS + 1;
	localparam int INC_W  = FRAC_BITS + 2;
	localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(NUM_W + 1);

	localparam logic [ACC_W-1:0] HALF_ULP = ACC_W'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic                  start;
		logic [COORD_BITS-1:0] num;
		logic [COORD_BITS-1:0] den;
	} dlr_div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} dlr_div_rsp_t;

endpackage

FILE: hdl/dlr_ifs.sv
// request and pixel channel interfaces
interface dlr_line_if;
	logic                              valid;
	logic                              ready;
	logic [dlr_pkg::FIELD_BITS-1:0]    x_start;
	logic [dlr_pkg::FIELD_BITS-1:0]    y_start;
	logic [dlr_pkg::FIELD_BITS-1:0]    x_end;
	logic [dlr_pkg::FIELD_BITS-1:0]    y_end;

	modport source (output valid, x_start, y_start, x_end, y_end, input ready);
	modport sink (input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dlr_pixel_if;
	logic                              valid;
	logic                              ready;
	logic [dlr_pkg::FIELD_BITS-1:0]    pixel_x;
	logic [dlr_pkg::FIELD_BITS-1:0]    pixel_y;
	logic                              last_pixel;

	modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

FILE: hdl/dlr_divider.sv
// shared bit-serial restoring divider for the fixed-point step increments
`include "assert_macros.svh"

module dlr_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dlr_pkg::dlr_div_req_t req,
	output dlr_pkg::dlr_div_rsp_t rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [dlr_pkg::CNT_W-1:0]        cnt_q;
	logic [dlr_pkg::COORD_BITS-1:0]   rem_q;
	logic [dlr_pkg::COORD_BITS-1:0]   den_q;
	logic [dlr_pkg::NUM_W-1:0]        num_q;
	logic [dlr_pkg::NUM_W-1:0]        quot_q;

	logic [dlr_pkg::COORD_BITS:0]     trial;
	logic [dlr_pkg::COORD_BITS:0]     diff;
	logic                             ge;

	assign trial = {rem_q, num_q[dlr_pkg::NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dlr_pkg::CNT_W'(dlr_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			den_q  <= req.den;
			num_q  <= {req.num, {dlr_pkg::FRAC_BITS{1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[dlr_pkg::COORD_BITS-1:0] : trial[dlr_pkg::COORD_BITS-1:0];
			num_q  <= {num_q[dlr_pkg::NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[dlr_pkg::NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q[dlr_pkg::QUOT_W-1:0];

	`DLR_ASSERT_SAME(a_start_idle, req.start, !busy_q, "divider started while busy")
	`DLR_ASSERT_SAME(a_rem_bound, busy_q, rem_q < den_q, "partial remainder not below divisor")
	`DLR_ASSERT_SAME(a_quot_range, done_q,
		quot_q <= (dlr_pkg::NUM_W'(1) << dlr_pkg::FRAC_BITS), "increment above one pixel")

endmodule

FILE: hdl/dda_line_rasterizer_unit.sv
// dda line rasterizer top level: sequencer, accumulators and pixel output register
// when start equals end no division is done and the request goes straight to pixel output
// each request gives steps+1 pixels, one per cycle while pix.ready holds; a new request is taken only in idle
// the single shared bit-serial divider computes the x and then the y increment, one quotient bit per cycle
// reset clears the sequencer and the output valid
`include "assert_macros.svh"

module dda_line_rasterizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	dlr_line_if.sink    req,
	dlr_pixel_if.source pix
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIVX = 2'd1;
	localparam logic [1:0] ST_DIVY = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam int C = dlr_pkg::COORD_BITS;
	localparam int F = dlr_pkg::FRAC_BITS;

	logic [1:0]                     state_q;
	logic                           start_q;
	logic [C-1:0]                   adx_q, ady_q, steps_q, k_q;
	logic                           sx_q, sy_q;
	logic [dlr_pkg::INC_W-1:0]      xinc_q, yinc_q;
	logic [dlr_pkg::ACC_W-1:0]      xacc_q, yacc_q;
	logic                           out_valid_q;
	logic [C-1:0]                   px_q, py_q;
	logic                           last_q;

	logic [C-1:0]                   xs, ys, xe, ye;
	logic [C:0]                     dx, dy;
	logic [C-1:0]                   adx, ady, steps;
	logic                           accept;
	logic                           load;
	logic                           is_last;
	logic [dlr_pkg::INC_W-1:0]      qmag, qinc;
	logic [dlr_pkg::ACC_W-1:0]      xround, yround;
	dlr_pkg::dlr_div_req_t          div_req;
	dlr_pkg::dlr_div_rsp_t          div_rsp;

	assign xs = req.x_start[C-1:0];
	assign ys = req.y_start[C-1:0];
	assign xe = req.x_end[C-1:0];
	assign ye = req.y_end[C-1:0];
	assign dx = {1'b0, xe} - {1'b0, xs};
	assign dy = {1'b0, ye} - {1'b0, ys};
	assign adx = dx[C] ? xs - xe : dx[C-1:0];
	assign ady = dy[C] ? ys - ye : dy[C-1:0];
	assign steps = (adx > ady) ? adx : ady;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign load      = (state_q == ST_EMIT) && (!out_valid_q || pix.ready);
	assign is_last   = (k_q == steps_q);

	assign div_req.start = start_q;
	assign div_req.num   = (state_q == ST_DIVY) ? ady_q : adx_q;
	assign div_req.den   = steps_q;

	dlr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// truncation toward zero: negate the magnitude quotient
	assign qmag = {1'b0, div_rsp.quot};
	assign qinc = (((state_q == ST_DIVY) ? sy_q : sx_q)) ? (~qmag + 1'b1) : qmag;

	assign xround = xacc_q + dlr_pkg::HALF_ULP;
	assign yround = yacc_q + dlr_pkg::HALF_ULP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pix.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (steps == '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DIVX;
							start_q <= 1'b1;
						end
					end
				end
				ST_DIVX: begin
					if (div_rsp.done) begin
						state_q <= ST_DIVY;
						start_q <= 1'b1;
					end
				end
				ST_DIVY: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load && is_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			adx_q   <= adx;
			ady_q   <= ady;
			sx_q    <= dx[C];
			sy_q    <= dy[C];
			steps_q <= steps;
			k_q     <= '0;
			xinc_q  <= '0;
			yinc_q  <= '0;
			xacc_q  <= {1'b0, xs, {F{1'b0}}};
			yacc_q  <= {1'b0, ys, {F{1'b0}}};
		end
		if (div_rsp.done && state_q == ST_DIVX) begin
			xinc_q <= qinc;
		end
		if (div_rsp.done && state_q == ST_DIVY) begin
			yinc_q <= qinc;
		end
		if (load) begin
			px_q   <= xround[F +: C];
			py_q   <= yround[F +: C];
			last_q <= is_last;
			k_q    <= k_q + 1'b1;
			xacc_q <= xacc_q + {{(dlr_pkg::ACC_W-dlr_pkg::INC_W){xinc_q[dlr_pkg::INC_W-1]}}, xinc_q};
			yacc_q <= yacc_q + {{(dlr_pkg::ACC_W-dlr_pkg::INC_W){yinc_q[dlr_pkg::INC_W-1]}}, yinc_q};
		end
	end

	assign pix.valid      = out_valid_q;
	assign pix.pixel_x    = dlr_pkg::FIELD_BITS'(px_q);
	assign pix.pixel_y    = dlr_pkg::FIELD_BITS'(py_q);
	assign pix.last_pixel = last_q;

	`DLR_ASSERT_SAME(a_k_bound, state_q == ST_EMIT, k_q <= steps_q, "pixel index past step count")
	`DLR_ASSERT_NEXT(a_point_line, accept && steps == '0, state_q == ST_EMIT,
		"single point request did not go straight to output")
	`DLR_ASSERT_SAME(a_done_in_div, div_rsp.done, state_q == ST_DIVX || state_q == ST_DIVY,
		"divider finished outside a division state")

endmodule
